/* hw/rtl/mmac_pkg.sv */
// Shared constants and register codes for the magnetometer averaging and calibration block.
package mmac_pkg;

  localparam int AXES              = 3;
  localparam int SAMPLE_W          = 16;
  localparam int SCALED_W          = 18;
  localparam int GAIN_W            = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 16;

  localparam int WINDOW_DEFAULT    = 10;
  localparam int GAIN_FRAC_DEFAULT = 14;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  localparam logic signed [SCALED_W-1:0] SCALED_MAX = 18'sd131071;
  localparam logic signed [SCALED_W-1:0] SCALED_MIN = -18'sd131072;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z   = 3'd5;

  // Item actions.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CALIB  = 1'b1;

endpackage

/* hw/rtl/mmac_if.sv */
// Valid/ready channel interfaces for samples, results and configuration writes.
interface mmac_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  sample_x;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  sample_y;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  sample_z;

  modport source (output valid, action, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, action, sample_x, sample_y, sample_z, output ready);
endinterface

interface mmac_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  avg_x;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  avg_y;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  avg_z;
  logic signed [mmac_pkg::SCALED_W-1:0]  scaled_x;
  logic signed [mmac_pkg::SCALED_W-1:0]  scaled_y;
  logic signed [mmac_pkg::SCALED_W-1:0]  scaled_z;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  low_x;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  low_y;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  low_z;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  high_x;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  high_y;
  logic signed [mmac_pkg::SAMPLE_W-1:0]  high_z;

  modport source (output valid, avg_x, avg_y, avg_z, scaled_x, scaled_y, scaled_z,
                  low_x, low_y, low_z, high_x, high_y, high_z, input ready);
  modport sink   (input valid, avg_x, avg_y, avg_z, scaled_x, scaled_y, scaled_z,
                  low_x, low_y, low_z, high_x, high_y, high_z, output ready);
endinterface

interface mmac_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mmac_pkg::CFG_IDX_W-1:0]      index;
  logic [mmac_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/magnetometer_moving_average_calib.sv */
// Three-axis moving average with min/max calibration tracking and offset/gain correction.
// An accepted sample beat is registered at every pipeline stage on its way to its result beat.
// Throughput: one beat per cycle unless stalled; ring read at acceptance and written in stage 1.
// Every stage holds under back-pressure, and free stages keep taking beats while a result waits.
// Reset (synchronous, rst high) empties the pipeline, clears the ring valid bits, sums, min/max
// and the calibrating flag at once, and restores offsets to zero and gains to one.
module magnetometer_moving_average_calib #(
  parameter int WINDOW             = mmac_pkg::WINDOW_DEFAULT,
  parameter int GAIN_FRACTION_BITS = mmac_pkg::GAIN_FRAC_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  mmac_cfg_if.sink       cfg,
  mmac_in_if.sink        samples,
  mmac_out_if.source     results
);

  localparam int AXES   = mmac_pkg::AXES;
  localparam int SW     = mmac_pkg::SAMPLE_W;
  localparam int GW     = mmac_pkg::GAIN_W;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int MAG_W  = $clog2(32768 * WINDOW + 1);
  localparam int SUM_W  = MAG_W + 1;
  localparam int PROD_W = SW + 1 + GW + 1;
  localparam int NST    = 9;

  // Reciprocal of the window, scaled by 2^MAG_W and rounded down; the quotient is then
  // at most one short and a single correction step fixes it.
  localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'd1 << MAG_W) / WINDOW);
  localparam logic [MAG_W-1:0] WIN_C = MAG_W'(WINDOW);
  localparam logic signed [PROD_W:0] HALF = (PROD_W+1)'(1) <<< (GAIN_FRACTION_BITS - 1);

  // Pipeline control.
  logic [NST:1] vld;
  logic [NST:1] ce;
  logic         in_fire;

  always_comb begin
    ce[NST] = !vld[NST] || results.ready;
    for (int k = NST - 1; k >= 1; k--) begin
      ce[k] = !vld[k] || ce[k+1];
    end
  end

  assign samples.ready = ce[1];
  assign in_fire       = samples.valid && ce[1];
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ce[1]) begin
        vld[1] <= samples.valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (ce[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Configuration registers.
  logic signed [SW-1:0] offset [AXES];
  logic [GW-1:0]        gain   [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        offset[a] <= '0;
        gain[a]   <= mmac_pkg::GAIN_RESET;
      end
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mmac_pkg::REG_OFFSET_X: offset[0] <= $signed(cfg.data);
        mmac_pkg::REG_OFFSET_Y: offset[1] <= $signed(cfg.data);
        mmac_pkg::REG_OFFSET_Z: offset[2] <= $signed(cfg.data);
        mmac_pkg::REG_GAIN_X:   gain[0]   <= cfg.data;
        mmac_pkg::REG_GAIN_Y:   gain[1]   <= cfg.data;
        mmac_pkg::REG_GAIN_Z:   gain[2]   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sample ring: one word of three axes per slot, with a valid bit per slot so that
  // slots never written since reset read as zero.
  logic [AXES*SW-1:0] ring [WINDOW];
  logic [WINDOW-1:0]  ring_vld;
  logic [SLOT_W-1:0]  ring_slot;
  logic [AXES*SW-1:0] rd_data;
  logic               rd_vld;

  // Stage 1: ring read data arrives, running sums are updated and the slot written back.
  logic                 p1_act;
  logic signed [SW-1:0] p1_smp [AXES];
  logic [SLOT_W-1:0]    p1_slot;
  logic signed [SUM_W-1:0] window_sums [AXES];
  logic signed [SUM_W-1:0] sum_next    [AXES];
  logic signed [SW-1:0]    old_smp     [AXES];
  logic                    fire1;

  assign fire1 = vld[1] && ce[2];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= ring[ring_slot];
    end
    if (fire1 && p1_act == mmac_pkg::ACT_SAMPLE) begin
      ring[p1_slot] <= {p1_smp[2], p1_smp[1], p1_smp[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld  <= '0;
      ring_slot <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_vld <= ring_vld[ring_slot];
        if (samples.action == mmac_pkg::ACT_SAMPLE) begin
          if (ring_slot == SLOT_W'(WINDOW - 1)) begin
            ring_slot <= '0;
          end else begin
            ring_slot <= ring_slot + 1'b1;
          end
        end
      end
      if (fire1 && p1_act == mmac_pkg::ACT_SAMPLE) begin
        ring_vld[p1_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce[1]) begin
      p1_act    <= samples.action;
      p1_smp[0] <= samples.sample_x;
      p1_smp[1] <= samples.sample_y;
      p1_smp[2] <= samples.sample_z;
      p1_slot   <= ring_slot;
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      old_smp[a] = rd_vld ? $signed(rd_data[a*SW +: SW]) : '0;
      if (p1_act == mmac_pkg::ACT_SAMPLE) begin
        sum_next[a] = window_sums[a] + SUM_W'(p1_smp[a]) - SUM_W'(old_smp[a]);
      end else begin
        sum_next[a] = window_sums[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        window_sums[a] <= '0;
      end
    end else if (fire1) begin
      for (int a = 0; a < AXES; a++) begin
        window_sums[a] <= sum_next[a];
      end
    end
  end

  // A start-calibration beat carries the unchanged sum, which divides to the last average.
  logic                    p2_act;
  logic signed [SUM_W-1:0] p2_sum [AXES];

  always_ff @(posedge clk) begin
    if (ce[2]) begin
      p2_act <= p1_act;
      p2_sum <= sum_next;
    end
  end

  // Stage 2: split the sum into sign and magnitude so the division works on positives.
  logic             p3_act;
  logic             p3_neg [AXES];
  logic [MAG_W-1:0] p3_mag [AXES];

  always_ff @(posedge clk) begin
    if (ce[3]) begin
      p3_act <= p2_act;
      for (int a = 0; a < AXES; a++) begin
        p3_neg[a] <= p2_sum[a][SUM_W-1];
        p3_mag[a] <= MAG_W'(p2_sum[a][SUM_W-1] ? -p2_sum[a] : p2_sum[a]);
      end
    end
  end

  // Stage 3: multiply by the reciprocal for an estimate of the quotient.
  logic             p4_act;
  logic             p4_neg [AXES];
  logic [MAG_W-1:0] p4_mag [AXES];
  logic [MAG_W-1:0] p4_q0  [AXES];
  logic [2*MAG_W-1:0] recip_prod [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      recip_prod[a] = (2*MAG_W)'(p3_mag[a]) * (2*MAG_W)'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (ce[4]) begin
      p4_act <= p3_act;
      p4_neg <= p3_neg;
      p4_mag <= p3_mag;
      for (int a = 0; a < AXES; a++) begin
        p4_q0[a] <= recip_prod[a][2*MAG_W-1:MAG_W];
      end
    end
  end

  // Stage 4: one correction step when the remainder still reaches the window length.
  logic             p5_act;
  logic             p5_neg [AXES];
  logic [SW-1:0]    p5_q   [AXES];
  logic [MAG_W-1:0] rem    [AXES];
  logic [MAG_W-1:0] q_fix  [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rem[a]   = p4_mag[a] - MAG_W'(p4_q0[a] * WIN_C);
      q_fix[a] = (rem[a] >= WIN_C) ? p4_q0[a] + 1'b1 : p4_q0[a];
    end
  end

  always_ff @(posedge clk) begin
    if (ce[5]) begin
      p5_act <= p4_act;
      p5_neg <= p4_neg;
      for (int a = 0; a < AXES; a++) begin
        p5_q[a] <= q_fix[a][SW-1:0];
      end
    end
  end

  // Stage 5: restore the sign, truncating toward zero, and track the extremes.
  logic                 calibrating;
  logic signed [SW-1:0] axis_minima [AXES];
  logic signed [SW-1:0] axis_maxima [AXES];
  logic signed [SW-1:0] avg_c  [AXES];
  logic signed [SW-1:0] low_n  [AXES];
  logic signed [SW-1:0] high_n [AXES];
  logic                 fire5;

  assign fire5 = vld[5] && ce[6];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      avg_c[a] = $signed(p5_neg[a] ? SW'('0) - p5_q[a] : p5_q[a]);
      low_n[a]  = axis_minima[a];
      high_n[a] = axis_maxima[a];
      if (p5_act == mmac_pkg::ACT_CALIB) begin
        low_n[a]  = '0;
        high_n[a] = '0;
      end else if (calibrating) begin
        if (avg_c[a] < axis_minima[a]) begin
          low_n[a] = avg_c[a];
        end
        if (avg_c[a] > axis_maxima[a]) begin
          high_n[a] = avg_c[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        axis_minima[a] <= '0;
        axis_maxima[a] <= '0;
      end
    end else if (fire5) begin
      if (p5_act == mmac_pkg::ACT_CALIB) begin
        calibrating <= 1'b1;
      end
      axis_minima <= low_n;
      axis_maxima <= high_n;
    end
  end

  logic signed [SW-1:0] p6_avg  [AXES];
  logic signed [SW-1:0] p6_low  [AXES];
  logic signed [SW-1:0] p6_high [AXES];

  always_ff @(posedge clk) begin
    if (ce[6]) begin
      p6_avg  <= avg_c;
      p6_low  <= low_n;
      p6_high <= high_n;
    end
  end

  // Stage 6: subtract the hard-iron offset.
  logic signed [SW-1:0] p7_avg  [AXES];
  logic signed [SW-1:0] p7_low  [AXES];
  logic signed [SW-1:0] p7_high [AXES];
  logic signed [SW:0]   p7_diff [AXES];

  always_ff @(posedge clk) begin
    if (ce[7]) begin
      p7_avg  <= p6_avg;
      p7_low  <= p6_low;
      p7_high <= p6_high;
      for (int a = 0; a < AXES; a++) begin
        p7_diff[a] <= (SW+1)'(p6_avg[a]) - (SW+1)'(offset[a]);
      end
    end
  end

  // Stage 7: apply the gain.
  logic signed [SW-1:0]     p8_avg  [AXES];
  logic signed [SW-1:0]     p8_low  [AXES];
  logic signed [SW-1:0]     p8_high [AXES];
  logic signed [PROD_W-1:0] p8_prod [AXES];

  always_ff @(posedge clk) begin
    if (ce[8]) begin
      p8_avg  <= p7_avg;
      p8_low  <= p7_low;
      p8_high <= p7_high;
      for (int a = 0; a < AXES; a++) begin
        p8_prod[a] <= p7_diff[a] * $signed({1'b0, gain[a]});
      end
    end
  end

  // Stage 8: round half up, drop the fraction bits and saturate into the output register.
  logic signed [PROD_W:0]             rnd    [AXES];
  logic signed [PROD_W:0]             shr    [AXES];
  logic signed [mmac_pkg::SCALED_W-1:0] sat_c [AXES];
  logic signed [mmac_pkg::SCALED_W-1:0] o_scaled [AXES];
  logic signed [SW-1:0]               o_avg  [AXES];
  logic signed [SW-1:0]               o_low  [AXES];
  logic signed [SW-1:0]               o_high [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rnd[a] = (PROD_W+1)'(p8_prod[a]) + HALF;
      shr[a] = rnd[a] >>> GAIN_FRACTION_BITS;
      if (shr[a] > (PROD_W+1)'(mmac_pkg::SCALED_MAX)) begin
        sat_c[a] = mmac_pkg::SCALED_MAX;
      end else if (shr[a] < (PROD_W+1)'(mmac_pkg::SCALED_MIN)) begin
        sat_c[a] = mmac_pkg::SCALED_MIN;
      end else begin
        sat_c[a] = shr[a][mmac_pkg::SCALED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce[9]) begin
      o_avg    <= p8_avg;
      o_low    <= p8_low;
      o_high   <= p8_high;
      o_scaled <= sat_c;
    end
  end

  assign results.valid    = vld[NST];
  assign results.avg_x    = o_avg[0];
  assign results.avg_y    = o_avg[1];
  assign results.avg_z    = o_avg[2];
  assign results.scaled_x = o_scaled[0];
  assign results.scaled_y = o_scaled[1];
  assign results.scaled_z = o_scaled[2];
  assign results.low_x    = o_low[0];
  assign results.low_y    = o_low[1];
  assign results.low_z    = o_low[2];
  assign results.high_x   = o_high[0];
  assign results.high_y   = o_high[1];
  assign results.high_z   = o_high[2];

endmodule

/* hw/rtl/mmac_check.sv */
// Port-level assertions for the magnetometer averaging block, bound to its top level.
module mmac_check (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [mmac_pkg::SAMPLE_W-1:0] avg_x,
  input logic signed [mmac_pkg::SCALED_W-1:0] scaled_x,
  input logic signed [mmac_pkg::SAMPLE_W-1:0] low_x,
  input logic signed [mmac_pkg::SAMPLE_W-1:0] low_y,
  input logic signed [mmac_pkg::SAMPLE_W-1:0] low_z,
  input logic signed [mmac_pkg::SAMPLE_W-1:0] high_x,
  input logic signed [mmac_pkg::SAMPLE_W-1:0] high_y,
  input logic signed [mmac_pkg::SAMPLE_W-1:0] high_z
);

  // Reset empties the pipeline, so no result is offered in the following cycle.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(avg_x) && $stable(scaled_x))
    else $error("stalled result changed");

  // The block only pushes back on samples when a result is waiting at the output.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // Extremes start from zero, so the minimum never rises above it nor the maximum below it.
  a_extremes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (low_x <= 0) && (low_y <= 0) && (low_z <= 0) &&
                  (high_x >= 0) && (high_y >= 0) && (high_z >= 0))
    else $error("tracked extreme on the wrong side of zero");

endmodule

bind magnetometer_moving_average_calib mmac_check u_mmac_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .avg_x     (results.avg_x),
  .scaled_x  (results.scaled_x),
  .low_x     (results.low_x),
  .low_y     (results.low_y),
  .low_z     (results.low_z),
  .high_x    (results.high_x),
  .high_y    (results.high_y),
  .high_z    (results.high_z)
);

/* tb/mag_average_calc_pkg.sv */
// Running model of the three-axis average, calibration tracking and gain stage, with result check.
package mag_average_calc_pkg;
  import mmac_pkg::*;

  typedef struct packed {
    logic [AXES-1:0][SAMPLE_W-1:0] avg;
    logic [AXES-1:0][SCALED_W-1:0] scaled;
    logic [AXES-1:0][SAMPLE_W-1:0] low;
    logic [AXES-1:0][SAMPLE_W-1:0] high;
  } reading_t;

  class mag_average_calc;
    shortint          ring[AXES][WINDOW_DEFAULT];
    int               sums[AXES];
    shortint          avgs[AXES];
    shortint          lows[AXES];
    shortint          highs[AXES];
    shortint          offsets[AXES];
    bit [GAIN_W-1:0]  gains[AXES];
    int               slot;
    bit               calibrating;
    string            axis_tag[AXES] = '{"x", "y", "z"};

    reading_t         owed_readings[$];
    int               faults;
    int               samples_seen;
    int               calib_starts;
    int               readings_checked;
    int               clipped;

    function new();
      foreach (gains[a]) gains[a] = GAIN_RESET;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OFFSET_X: offsets[0] = data;
        REG_OFFSET_Y: offsets[1] = data;
        REG_OFFSET_Z: offsets[2] = data;
        REG_GAIN_X:   gains[0] = data;
        REG_GAIN_Y:   gains[1] = data;
        REG_GAIN_Z:   gains[2] = data;
        default: ;
      endcase
    endfunction

    // Rounds half up by adding half an LSB before the arithmetic shift, then clips to 18 bits.
    function logic [SCALED_W-1:0] scaled_axis(int a);
      longint prod;
      longint q;
      prod = (longint'(avgs[a]) - longint'(offsets[a])) * longint'(gains[a]);
      q = (prod + (longint'(1) << (GAIN_FRAC_DEFAULT - 1))) >>> GAIN_FRAC_DEFAULT;
      if (q > longint'(SCALED_MAX)) begin
        q = longint'(SCALED_MAX);
        clipped++;
      end else if (q < longint'(SCALED_MIN)) begin
        q = longint'(SCALED_MIN);
        clipped++;
      end
      return q[SCALED_W-1:0];
    endfunction

    function void take_sample_beat(logic act, shortint sx, shortint sy, shortint sz);
      shortint  s[AXES];
      reading_t r;
      s = '{sx, sy, sz};
      if (act == ACT_CALIB) begin
        calibrating = 1'b1;
        calib_starts++;
        foreach (lows[a]) begin
          lows[a] = 0;
          highs[a] = 0;
        end
      end else begin
        samples_seen++;
        foreach (s[a]) begin
          sums[a] += int'(s[a]) - int'(ring[a][slot]);
          ring[a][slot] = s[a];
          // SystemVerilog integer division truncates toward zero, as the block does.
          avgs[a] = shortint'(sums[a] / WINDOW_DEFAULT);
          if (calibrating) begin
            if (avgs[a] < lows[a]) lows[a] = avgs[a];
            if (avgs[a] > highs[a]) highs[a] = avgs[a];
          end
        end
        slot = (slot + 1) % WINDOW_DEFAULT;
      end
      foreach (avgs[a]) begin
        r.avg[a]    = avgs[a];
        r.scaled[a] = scaled_axis(a);
        r.low[a]    = lows[a];
        r.high[a]   = highs[a];
      end
      owed_readings.push_back(r);
    endfunction

    function void compare_field(string field, int a, int want, int got);
      if (want != got) begin
        $error("%s_%s expected %0d got %0d", field, axis_tag[a], want, got);
        faults++;
      end
    endfunction

    function void match_result_beat(reading_t got);
      reading_t want;
      if (owed_readings.size() == 0) begin
        $error("result beat arrived with no sample beat outstanding");
        faults++;
        return;
      end
      want = owed_readings.pop_front();
      readings_checked++;
      for (int a = 0; a < AXES; a++) begin
        compare_field("avg", a, $signed(want.avg[a]), $signed(got.avg[a]));
        compare_field("scaled", a, $signed(want.scaled[a]), $signed(got.scaled[a]));
        compare_field("low", a, $signed(want.low[a]), $signed(got.low[a]));
        compare_field("high", a, $signed(want.high[a]), $signed(got.high[a]));
      end
    endfunction
  endclass

endpackage

/* tb/magnetometer_moving_average_calib_test.sv */
// Top-level test of the magnetometer averaging block: stimulus, flow control and result checks.
module magnetometer_moving_average_calib_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mmac_pkg::*;
  import mag_average_calc_pkg::*;

  typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_HOLD} spread_e;

  localparam shortint FIELD_MAX      = 32767;
  localparam shortint FIELD_MIN      = -32768;
  localparam logic [GAIN_W-1:0] GAIN_FULL = 16'hFFFF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_GAIN_Z + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_GAIN_Z + 3'd2;
  localparam int SETTING_BLOCKS  = 6;
  localparam int ITEMS_PER_BLOCK = 258;
  localparam int RESTYLE_EVERY   = 16;
  localparam int CALIB_PCT       = 3;
  localparam int DRAIN_CYCLES    = 16;
  localparam int LONG_HOLD       = 300;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  logic clk;
  logic rst;

  mmac_in_if  samples_ch ();
  mmac_out_if results_ch ();
  mmac_cfg_if cfg_ch ();

  magnetometer_moving_average_calib uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (samples_ch),
    .results (results_ch)
  );

  mag_average_calc calc = new();

  int send_gap_pct;
  int stall_pct;
  int settings_used;
  bit hold_wanted;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Run stopped: results did not drain in time.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Every handshake is sampled on the pre-edge values, result first so that a beat accepted
  // on the same edge is never mistaken for the one leaving.
  always @(posedge clk) begin : watch
    reading_t seen;
    if (!rst) begin
      if (results_ch.valid && results_ch.ready) begin
        seen.avg    = {results_ch.avg_z, results_ch.avg_y, results_ch.avg_x};
        seen.scaled = {results_ch.scaled_z, results_ch.scaled_y, results_ch.scaled_x};
        seen.low    = {results_ch.low_z, results_ch.low_y, results_ch.low_x};
        seen.high   = {results_ch.high_z, results_ch.high_y, results_ch.high_x};
        calc.match_result_beat(seen);
      end
      if (samples_ch.valid && samples_ch.ready)
        calc.take_sample_beat(samples_ch.action, samples_ch.sample_x, samples_ch.sample_y,
                              samples_ch.sample_z);
      if (cfg_ch.valid && cfg_ch.ready)
        calc.write_register(cfg_ch.index, cfg_ch.data);
    end
  end

  // Result side: random stalls, plus one long hold-off to let the pipeline back up.
  initial begin
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_done) begin
        results_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(logic act, shortint x, shortint y, shortint z);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid    <= 1'b1;
    samples_ch.action   <= act;
    samples_ch.sample_x <= x;
    samples_ch.sample_y <= y;
    samples_ch.sample_z <= z;
    do @(posedge clk); while (!samples_ch.ready);
  endtask

  // Leaves valid high; the caller drops it once the last write of a batch has gone.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_setting(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                              logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_Y, gy);
    write_reg(REG_GAIN_Z, gz);
  endtask

  // Registers change only with the pipeline empty, so every result reflects one setting.
  // It first lets the monitor note the last sample beat before waiting on the owed results.
  task automatic settle();
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (calc.owed_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] draw_offset();
    return $urandom_range(1) ? 16'($urandom) : 16'(int'($urandom_range(4000)) - 2000);
  endfunction

  function automatic logic [15:0] draw_gain();
    return $urandom_range(1) ? 16'($urandom)
                             : 16'(int'(GAIN_RESET) + int'($urandom_range(16000)) - 8000);
  endfunction

  function automatic shortint draw_axis(spread_e how, int centre);
    int v;
    case (how)
      SPREAD_FULL: v = int'(shortint'($urandom));
      SPREAD_NEAR: v = centre + int'($urandom_range(600)) - 300;
      default:     v = ($urandom_range(9) == 0) ? int'(shortint'($urandom)) : centre;
    endcase
    if (v > FIELD_MAX) v = FIELD_MAX;
    if (v < FIELD_MIN) v = FIELD_MIN;
    return shortint'(v);
  endfunction

  // Each axis keeps a style for a run of beats, so that held extremes drive the window
  // averages to full scale and the scaled values into clipping.
  task automatic random_items(int count);
    spread_e spread[AXES];
    int      centre[AXES];
    shortint s[AXES];
    logic    act;
    for (int n = 0; n < count; n++) begin
      if (n % RESTYLE_EVERY == 0) begin
        foreach (spread[a]) begin
          spread[a] = spread_e'($urandom_range(2));
          centre[a] = $urandom_range(1) ? ($urandom_range(1) ? FIELD_MAX : FIELD_MIN)
                                        : int'($urandom_range(65535)) - 32768;
        end
      end
      foreach (s[a]) s[a] = draw_axis(spread[a], centre[a]);
      act = ($urandom_range(99) < CALIB_PCT) ? ACT_CALIB : ACT_SAMPLE;
      send_item(act, s[0], s[1], s[2]);
    end
  endtask

  initial begin
    rst                 = 1'b1;
    samples_ch.valid    = 1'b0;
    samples_ch.action   = ACT_SAMPLE;
    samples_ch.sample_x = '0;
    samples_ch.sample_y = '0;
    samples_ch.sample_z = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_OFFSET_X;
    cfg_ch.data         = '0;
    send_gap_pct        = 32;
    stall_pct           = 77;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: zero offsets, unity gains.
    settings_used = 1;
    send_item(ACT_SAMPLE, 0, 0, 0);
    send_item(ACT_SAMPLE, FIELD_MAX, FIELD_MIN, FIELD_MAX);
    send_item(ACT_SAMPLE, FIELD_MIN, FIELD_MAX, FIELD_MIN);
    // Calibration start ignores whatever sits on the sample fields.
    send_item(ACT_CALIB, -1, 12345, FIELD_MIN);
    // One beat past a full window checks the ring wrap and min/max at full scale.
    repeat (WINDOW_DEFAULT + 1) send_item(ACT_SAMPLE, FIELD_MAX, FIELD_MIN, -1);
    send_item(ACT_CALIB, 0, 0, 0);
    // Small negative z sums check truncation toward zero rather than flooring.
    repeat (3) send_item(ACT_SAMPLE, FIELD_MIN, FIELD_MAX, -5);

    for (int blk = 0; blk < SETTING_BLOCKS; blk++) begin
      settle();
      case (blk)
        0: load_setting(FIELD_MAX, FIELD_MIN, 0, GAIN_FULL, 0, GAIN_RESET);
        1: load_setting(FIELD_MIN, FIELD_MAX, 0, GAIN_FULL, GAIN_FULL, 0);
        default: load_setting(draw_offset(), draw_offset(), draw_offset(),
                              draw_gain(), draw_gain(), draw_gain());
      endcase
      // Indexes past the last register must leave the setting alone.
      if (blk == 0) write_reg(REG_SPARE_LO, 16'($urandom));
      if (blk == SETTING_BLOCKS - 1) write_reg(REG_SPARE_HI, 16'($urandom));
      cfg_ch.valid <= 1'b0;
      settings_used++;
      if (blk < 2) begin
        send_gap_pct = 32;
        stall_pct    = 77;
      end else if (blk < 4) begin
        send_gap_pct = 77;
        stall_pct    = 32;
      end else begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      if (blk == 4) hold_wanted = 1'b1;
      random_items(ITEMS_PER_BLOCK);
    end
    settle();

    $display("Covered %0d sample beats and %0d calibration starts across %0d register settings.",
             calc.samples_seen, calc.calib_starts, settings_used);
    $display("Checked %0d result beats; %0d scaled fields were expected to clip.",
             calc.readings_checked, calc.clipped);
    if (calc.faults == 0 && calc.owed_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
